### rtl/ftsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftsa_pkg
// Shared types, constants, and the window and saturation functions for the
// fine-tune step accelerator.
// ----------------------------------------------------------------------------
package ftsa_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 27;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 88;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_STEP   = 3'd0,
        REG_FAST_STEP     = 3'd1,
        REG_SHORT_GAP_MS  = 3'd2,
        REG_CANCEL_GAP_MS = 3'd3,
        REG_TRIGGER_COUNT = 3'd4,
        REG_ZOOM_LEVEL    = 3'd5,
        REG_CENTER_FREQ   = 3'd6,
        REG_CAL_MODE      = 3'd7
    } cfg_idx_t;

    // item kinds
    localparam logic KIND_STEP = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // direction / move codes
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_CW   = 2'b01;
    localparam logic [1:0] DIR_CCW  = 2'b11;

    // register reset values
    localparam logic [16:0] RST_NORMAL_STEP   = 17'd100;
    localparam logic [16:0] RST_FAST_STEP     = 17'd500;
    localparam logic [13:0] RST_SHORT_GAP_MS  = 14'd30;
    localparam logic [15:0] RST_CANCEL_GAP_MS = 16'd400;
    localparam logic [3:0]  RST_TRIGGER_COUNT = 4'd4;
    localparam logic [2:0]  RST_ZOOM_LEVEL    = 3'd0;
    localparam logic [26:0] RST_CENTER_FREQ   = 27'd7000000;
    localparam logic        RST_CAL_MODE      = 1'b0;

    localparam logic [3:0] CNT_MAX = 4'd15;

    // recenter window bounds
    localparam logic signed [31:0] WIN0_HIGH    = 32'sd142000;
    localparam logic signed [31:0] WIN0_LOW     = -32'sd43000;
    localparam logic signed [31:0] WINZ_HIGH    = 32'sd95000;
    localparam logic signed [31:0] WINZ_LOW_MAG = 32'sd93000;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = -32'sh8000_0000;

    typedef struct packed {
        logic [16:0] normal_step;
        logic [16:0] fast_step;
        logic [13:0] short_gap_ms;
        logic [15:0] cancel_gap_ms;
        logic [3:0]  trigger_count;
        logic [2:0]  zoom_level;
        logic [26:0] center_freq;
        logic        cal_mode;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         direction;
        logic [31:0]        time_ms;
        logic signed [31:0] load_value;
    } item_t;

    typedef struct packed {
        logic [1:0]         move;
        logic signed [31:0] offset_hz;
        logic signed [31:0] tuned_freq;
        logic               recenter_request;
        logic               fast_active;
        logic [16:0]        step_used;
    } result_t;

    // true when the offset lies outside the recenter window for this zoom
    function automatic logic outside_win(input logic signed [31:0] off,
                                         input logic [2:0] zoom);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        hi = WINZ_HIGH >>> zoom;
        lo = -(WINZ_LOW_MAG >>> zoom);
        if (zoom == 3'd0)
        begin
            return (off > WIN0_HIGH) || (off < WIN0_LOW);
        end
        return (off >= hi) || (off < lo);
    endfunction

    // clamp a 33-bit signed sum into 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31])
        begin
            return v[32] ? S32_MIN : S32_MAX;
        end
        return v[31:0];
    endfunction

endpackage

### rtl/ftsa_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftsa_cfg_regs
// Configuration register file, write-only, one register per index.
// ----------------------------------------------------------------------------
module ftsa_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ftsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ftsa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output ftsa_pkg::cfg_t                     cfg
);
    import ftsa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_NORMAL_STEP:   cfg_next.normal_step   = cfg_wdata[16:0];
                REG_FAST_STEP:     cfg_next.fast_step     = cfg_wdata[16:0];
                REG_SHORT_GAP_MS:  cfg_next.short_gap_ms  = cfg_wdata[13:0];
                REG_CANCEL_GAP_MS: cfg_next.cancel_gap_ms = cfg_wdata[15:0];
                REG_TRIGGER_COUNT: cfg_next.trigger_count = cfg_wdata[3:0];
                REG_ZOOM_LEVEL:    cfg_next.zoom_level    = cfg_wdata[2:0];
                REG_CENTER_FREQ:   cfg_next.center_freq   = cfg_wdata[26:0];
                REG_CAL_MODE:      cfg_next.cal_mode      = cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.normal_step   <= RST_NORMAL_STEP;
            cfg_reg.fast_step     <= RST_FAST_STEP;
            cfg_reg.short_gap_ms  <= RST_SHORT_GAP_MS;
            cfg_reg.cancel_gap_ms <= RST_CANCEL_GAP_MS;
            cfg_reg.trigger_count <= RST_TRIGGER_COUNT;
            cfg_reg.zoom_level    <= RST_ZOOM_LEVEL;
            cfg_reg.center_freq   <= RST_CENTER_FREQ;
            cfg_reg.cal_mode      <= RST_CAL_MODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/ftsa_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftsa_step_core
// Knob timing state, fast-mode control and offset update for one word.
// ----------------------------------------------------------------------------
module ftsa_step_core (
    input  logic              clk,
    input  logic              rst_n,
    input  ftsa_pkg::cfg_t    cfg,
    input  ftsa_pkg::item_t   item,
    input  logic              commit,
    output ftsa_pkg::result_t res
);
    import ftsa_pkg::*;

    logic [31:0]        last_time_reg;
    logic [31:0]        last_time_next;
    logic               fast_on_reg;
    logic               fast_on_next;
    logic [3:0]         cnt_reg;
    logic [3:0]         cnt_next;
    logic signed [31:0] offset_reg;
    logic signed [31:0] offset_next;

    logic [1:0]         move;
    logic [31:0]        gap;
    logic [3:0]         cnt_inc;
    logic [16:0]        step_new;
    logic signed [32:0] step_sum;
    logic signed [32:0] tuned_sum;

    always_comb
    begin
        last_time_next = last_time_reg;
        fast_on_next   = fast_on_reg;
        cnt_next       = cnt_reg;
        offset_next    = offset_reg;

        // -2 counts as counter-clockwise
        unique case (item.direction)
            2'b00:   move = DIR_NONE;
            2'b01:   move = DIR_CW;
            default: move = DIR_CCW;
        endcase

        gap     = item.time_ms - last_time_reg;
        cnt_inc = cnt_reg;
        if ((gap <= {18'd0, cfg.short_gap_ms}) && (cnt_reg < CNT_MAX))
        begin
            cnt_inc = cnt_reg + 4'd1;
        end

        res.recenter_request = 1'b0;

        if (item.kind == KIND_LOAD)
        begin
            offset_next          = item.load_value;
            move                 = DIR_NONE;
            res.recenter_request = outside_win(item.load_value, cfg.zoom_level);
        end
        else if (move == DIR_NONE)
        begin
            res.recenter_request = outside_win(offset_reg, cfg.zoom_level);
        end
        else if (!cfg.cal_mode)
        begin
            last_time_next = item.time_ms;
            if (fast_on_reg)
            begin
                if (gap >= {16'd0, cfg.cancel_gap_ms})
                begin
                    fast_on_next = 1'b0;
                end
            end
            else if (cnt_inc >= cfg.trigger_count)
            begin
                cnt_next     = 4'd0;
                fast_on_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end

        step_new = fast_on_next ? cfg.fast_step : cfg.normal_step;
        if (move == DIR_CW)
        begin
            step_sum = {offset_reg[31], offset_reg} + $signed({16'd0, step_new});
        end
        else
        begin
            step_sum = {offset_reg[31], offset_reg} - $signed({16'd0, step_new});
        end

        if ((item.kind == KIND_STEP) && (move != DIR_NONE) && !cfg.cal_mode)
        begin
            offset_next          = sat33(step_sum);
            res.recenter_request = outside_win(offset_next, cfg.zoom_level);
        end

        tuned_sum = {offset_next[31], offset_next} + $signed({6'd0, cfg.center_freq});

        res.move        = move;
        res.offset_hz   = offset_next;
        res.tuned_freq  = sat33(tuned_sum);
        res.fast_active = fast_on_next;
        res.step_used   = step_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            fast_on_reg   <= 1'b0;
            cnt_reg       <= '0;
            offset_reg    <= '0;
        end
        else if (commit)
        begin
            last_time_reg <= last_time_next;
            fast_on_reg   <= fast_on_next;
            cnt_reg       <= cnt_next;
            offset_reg    <= offset_next;
        end
    end

    // entering fast mode always clears the short-gap count
    a_fast_entry_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fast_on_reg) |-> (cnt_reg == 4'd0))
        else $error("fast mode entered with nonzero short-gap count");

    // state only moves on a committed word
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> ($stable(offset_reg) && $stable(fast_on_reg) && $stable(cnt_reg)
                     && $stable(last_time_reg)))
        else $error("step state changed without a committed word");

    // a calibration-mode step leaves all state untouched
    a_cal_step_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (item.kind == KIND_STEP) && cfg.cal_mode) |=>
        ($stable(offset_reg) && $stable(fast_on_reg) && $stable(cnt_reg)
         && $stable(last_time_reg)))
        else $error("calibration step altered state");

endmodule

### rtl/fine_tune_step_accelerator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fine_tune_step_accelerator
// Tuning knob step accelerator: fast-mode detection, saturating offset update
// and recenter window test.
//
//   channel   dir   handshake                 payload
//   s_axis    in    s_axis_tvalid/tready      tdata: direction, time_ms,
//                                             load_value; tuser: kind
//   m_axis    out   m_axis_tvalid/tready      tdata: move, offset_hz,
//                                             tuned_freq, recenter_request,
//                                             fast_active, step_used
//   cfg       in    cfg_we                    cfg_index, cfg_wdata
//
// One word per cycle sustained while m_axis is ready; each word passes the input
// register, then the result register, with the state update in between.
// rst_n clears the valid flags and the step state and loads the register defaults.
// Backpressure on m_axis stalls the input register; s_axis keeps taking a
// word as long as the input register is empty or moving.
// ----------------------------------------------------------------------------
module fine_tune_step_accelerator (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] direction, [33:2] time_ms, [65:34] load_value, [71:66] zero
    input  logic [ftsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] kind
    input  logic                                s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] move, [33:2] offset_hz, [65:34] tuned_freq, [66] recenter_request,
    // [67] fast_active, [84:68] step_used, [87:85] zero
    output logic [ftsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,

    input  logic                                cfg_we,
    input  logic [ftsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ftsa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import ftsa_pkg::*;

    cfg_t    cfg;
    item_t   s1_item_reg;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    logic    s1_adv;
    logic    in_fire;
    logic    commit;
    result_t res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    assign s1_adv        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign commit        = s1_valid_reg && s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.kind       <= s_axis_tuser;
            s1_item_reg.direction  <= s_axis_tdata[1:0];
            s1_item_reg.time_ms    <= s_axis_tdata[33:2];
            s1_item_reg.load_value <= s_axis_tdata[65:34];
        end
        if (commit)
        begin
            out_res_reg <= res;
        end
    end

    ftsa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ftsa_step_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (s1_item_reg),
        .commit (commit),
        .res    (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0,
                            out_res_reg.step_used,
                            out_res_reg.fast_active,
                            out_res_reg.recenter_request,
                            out_res_reg.tuned_freq,
                            out_res_reg.offset_hz,
                            out_res_reg.move};

    // a stalled word in the input register is not dropped
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("input register lost a stalled word");

    // an accepted word always lands in the input register
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted word missing from input register");

    // a committed word always shows up on the output
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("committed word missing from result register");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fine-tune step accelerator. Knob steps and
// offset loads go in on s_axis under random idle cycles and backpressure. A
// local model of the tuner works out the word each item should produce, and
// every m_axis word is compared field by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module testbench;
    import ftsa_pkg::*;

    localparam int CYCLE_LIMIT       = 400000;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int MAX_REPORTS       = 10;
    localparam int RANDOM_PHASES     = 20;
    localparam int PHASE_WORDS       = 95;
    localparam int DRAIN_CYCLES      = 10;
    // -2 on the direction field, handled as counter-clockwise
    localparam logic [1:0] DIR_CCW_ALT = 2'b10;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [1:0] direction, [33:2] time_ms, [65:34] load_value, [71:66] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // [0] kind
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [1:0] move, [33:2] offset_hz, [65:34] tuned_freq, [66] recenter_request,
    // [67] fast_active, [84:68] step_used, [87:85] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // tuner model state
    cfg_t        tuner_cfg;
    logic [31:0] last_step_ms;
    logic        fast_mode;
    logic [3:0]  short_steps;
    int          tune_offset;

    result_t     expected_q[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    logic [31:0] knob_clock;
    bit          src_steady = 1'b0;
    bit          sink_steady = 1'b0;
    logic        stall_active = 1'b0;
    event        stall_go;

    fine_tune_step_accelerator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // recenter window for the current zoom: inside when lo <= offset < hi
    function automatic void window_edges(output int hi, output int lo);
        int z;
        z = int'(tuner_cfg.zoom_level);
        if (z == 0)
        begin
            hi = int'(WIN0_HIGH) + 1;
            lo = int'(WIN0_LOW);
        end
        else
        begin
            hi = int'(WINZ_HIGH) >>> z;
            lo = -(int'(WINZ_LOW_MAG) >>> z);
        end
    endfunction

    function automatic int clamp_s32(input longint v);
        if (v > longint'(S32_MAX))
        begin
            return S32_MAX;
        end
        if (v < longint'(S32_MIN))
        begin
            return S32_MIN;
        end
        return int'(v);
    endfunction

    // advance the tuner model by one item and return the word it should give
    function automatic result_t tune_item(input item_t it);
        result_t     r;
        int          mv;
        int          hi;
        int          lo;
        logic [31:0] gap;
        logic [16:0] step_hz;
        bit          flagged;
        mv = 0;
        if (it.direction == DIR_CW)
        begin
            mv = 1;
        end
        else if (it.direction != DIR_NONE)
        begin
            mv = -1;
        end
        if (it.kind == KIND_LOAD)
        begin
            tune_offset = it.load_value;
            mv = 0;
        end
        else if (mv != 0 && !tuner_cfg.cal_mode)
        begin
            gap = it.time_ms - last_step_ms;
            last_step_ms = it.time_ms;
            if (fast_mode)
            begin
                if (gap >= 32'(tuner_cfg.cancel_gap_ms))
                begin
                    fast_mode = 1'b0;
                end
            end
            else
            begin
                // slow steps leave the counter alone
                if (gap <= 32'(tuner_cfg.short_gap_ms) && short_steps != CNT_MAX)
                begin
                    short_steps++;
                end
                if (short_steps >= tuner_cfg.trigger_count)
                begin
                    short_steps = '0;
                    fast_mode = 1'b1;
                end
            end
            step_hz = fast_mode ? tuner_cfg.fast_step : tuner_cfg.normal_step;
            tune_offset = clamp_s32(longint'(tune_offset) + longint'(mv) * longint'(step_hz));
        end
        window_edges(hi, lo);
        flagged = (tune_offset >= hi) || (tune_offset < lo);
        // calibration: the move is reported but nothing is flagged
        if (it.kind == KIND_STEP && mv != 0 && tuner_cfg.cal_mode)
        begin
            flagged = 1'b0;
        end
        r.move             = 2'(mv);
        r.offset_hz        = tune_offset;
        r.tuned_freq       = clamp_s32(longint'(tuner_cfg.center_freq) + longint'(tune_offset));
        r.recenter_request = flagged;
        r.fast_active      = fast_mode;
        r.step_used        = fast_mode ? tuner_cfg.fast_step : tuner_cfg.normal_step;
        return r;
    endfunction

    function automatic item_t step_item(input logic [1:0] dir, input logic [31:0] t);
        item_t it;
        it.kind       = KIND_STEP;
        it.direction  = dir;
        it.time_ms    = t;
        it.load_value = $urandom;
        return it;
    endfunction

    function automatic item_t load_item(input int v);
        item_t it;
        it.kind       = KIND_LOAD;
        it.direction  = 2'($urandom);
        it.time_ms    = $urandom;
        it.load_value = v;
        return it;
    endfunction

    // mostly step sequences paced around the gap thresholds, some loads, some noise
    function automatic item_t knob_item();
        item_t       it;
        int          sel;
        int          hi;
        int          lo;
        logic [31:0] gap;
        it.kind       = KIND_STEP;
        it.direction  = 2'($urandom);
        it.time_ms    = $urandom;
        it.load_value = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 5)
        begin
            it.kind = 1'($urandom);
        end
        else if (sel < 15)
        begin
            window_edges(hi, lo);
            it.kind = KIND_LOAD;
            case ($urandom_range(0, 5))
                0: it.load_value = hi + $urandom_range(0, 2) - 1;
                1: it.load_value = lo + $urandom_range(0, 2) - 1;
                2: it.load_value = S32_MAX - $urandom_range(0, 300000);
                3: it.load_value = S32_MIN + $urandom_range(0, 300000);
                4: it.load_value = $urandom_range(0, 400000) - 200000;
                default: ;
            endcase
        end
        else
        begin
            sel = $urandom_range(0, 99);
            if (sel < 50)
            begin
                gap = $urandom_range(0, tuner_cfg.short_gap_ms);
            end
            else if (sel < 65)
            begin
                case ($urandom_range(0, 3))
                    0: gap = 32'(tuner_cfg.short_gap_ms);
                    1: gap = tuner_cfg.short_gap_ms + 1;
                    2: gap = 32'(tuner_cfg.cancel_gap_ms);
                    default: gap = tuner_cfg.cancel_gap_ms - 1;
                endcase
            end
            else if (sel < 85)
            begin
                gap = $urandom_range(tuner_cfg.short_gap_ms + 1, tuner_cfg.cancel_gap_ms + 1);
            end
            else if (sel < 95)
            begin
                gap = tuner_cfg.cancel_gap_ms + $urandom_range(0, 5000);
            end
            else
            begin
                gap = $urandom;
            end
            it.time_ms = knob_clock + gap;
            knob_clock = it.time_ms;
            sel = $urandom_range(0, 99);
            it.direction = (sel < 45) ? DIR_CW :
                           (sel < 90) ? DIR_CCW :
                           (sel < 95) ? DIR_CCW_ALT : DIR_NONE;
        end
        return it;
    endfunction

    // zero, all ones of the register width, or a value in the usual range
    function automatic logic [CFG_DATA_W-1:0] pick_reg(input int w, input int unsigned lo,
                                                       input int unsigned hi);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CFG_DATA_W'((64'd1 << w) - 64'd1);
            default: return CFG_DATA_W'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        s.normal_step   = 17'(pick_reg(17, 1, 100000));
        s.fast_step     = 17'(pick_reg(17, 1, 100000));
        s.short_gap_ms  = 14'(pick_reg(14, 0, 10000));
        s.cancel_gap_ms = 16'(pick_reg(16, 0, 60000));
        s.trigger_count = 4'(pick_reg(4, 1, 15));
        s.zoom_level    = 3'(pick_reg(3, 0, 7));
        s.center_freq   = pick_reg(27, 0, 100000000);
        s.cal_mode      = ($urandom_range(0, 3) == 0);
        return s;
    endfunction

    task automatic note_mismatch(input string what, input logic [OUT_TDATA_W-1:0] want,
                                 input logic [OUT_TDATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t: %0s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endtask

    task automatic send_word(input item_t it);
        int idle;
        idle = src_steady ? 0 : $urandom_range(0, 11);
        if (idle > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= IN_TDATA_W'({it.load_value, it.time_ms, it.direction});
        do @(posedge clk); while (!s_axis_tready);
        expected_q.push_back(tune_item(it));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t s);
        drain();
        put_reg(REG_NORMAL_STEP,   CFG_DATA_W'(s.normal_step));
        put_reg(REG_FAST_STEP,     CFG_DATA_W'(s.fast_step));
        put_reg(REG_SHORT_GAP_MS,  CFG_DATA_W'(s.short_gap_ms));
        put_reg(REG_CANCEL_GAP_MS, CFG_DATA_W'(s.cancel_gap_ms));
        put_reg(REG_TRIGGER_COUNT, CFG_DATA_W'(s.trigger_count));
        put_reg(REG_ZOOM_LEVEL,    CFG_DATA_W'(s.zoom_level));
        put_reg(REG_CENTER_FREQ,   CFG_DATA_W'(s.center_freq));
        put_reg(REG_CAL_MODE,      CFG_DATA_W'(s.cal_mode));
        cfg_we <= 1'b0;
        tuner_cfg = s;
    endtask

    task automatic test_directed_defaults();
        send_word(step_item(DIR_NONE, 32'd5));
        send_word(load_item(WIN0_HIGH));
        send_word(load_item(WIN0_HIGH + 1));
        send_word(load_item(WIN0_LOW));
        send_word(load_item(WIN0_LOW - 1));
        send_word(load_item(S32_MAX));
        send_word(step_item(DIR_CW, 32'd100));        // offset and tuned_freq saturate
        send_word(load_item(S32_MIN));
        send_word(step_item(DIR_CCW_ALT, 32'd1000));  // saturates low
        send_word(load_item(0));
        // four closely spaced steps switch to the fast step
        for (int i = 1; i <= 4; i++)
        begin
            send_word(step_item(DIR_CW, 32'd1000 + 10 * i));
        end
        send_word(step_item(DIR_CW, 32'd1070));
        send_word(step_item(DIR_CCW, 32'd1469));      // just short of the cancel gap
        send_word(step_item(DIR_CCW, 32'd1869));      // cancels fast mode
        send_word(step_item(DIR_CW, 32'hffff_fff0));
        send_word(step_item(DIR_CW, 32'd5));          // gap across the timestamp wrap
        send_word(load_item(300000));
        send_word(step_item(DIR_NONE, 32'd9));
    endtask

    task automatic test_register_extremes();
        cfg_t s;
        s.normal_step   = '0;
        s.fast_step     = '1;
        s.short_gap_ms  = '1;
        s.cancel_gap_ms = '0;
        s.trigger_count = '0;
        s.zoom_level    = '1;
        s.center_freq   = '1;
        s.cal_mode      = 1'b0;
        apply_settings(s);
        repeat (40) send_word(knob_item());
        s.normal_step   = '1;
        s.fast_step     = '0;
        s.short_gap_ms  = '0;
        s.cancel_gap_ms = '1;
        s.trigger_count = '1;
        s.zoom_level    = 3'd4;
        s.center_freq   = '0;
        s.cal_mode      = 1'b1;
        apply_settings(s);
        repeat (40) send_word(knob_item());
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            apply_settings(random_settings());
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            repeat (PHASE_WORDS) send_word(knob_item());
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // sink holds off long enough for the block to fill and stall its input
    task automatic test_long_stall();
        cfg_t s;
        s = random_settings();
        s.cal_mode = 1'b0;
        apply_settings(s);
        src_steady = 1'b1;
        -> stall_go;
        repeat (60) send_word(knob_item());
        src_steady = 1'b0;
    endtask

    initial
    begin : long_hold
        forever
        begin
            @(stall_go);
            stall_active <= 1'b1;
            repeat (LONG_STALL_CYCLES) @(posedge clk);
            stall_active <= 1'b0;
        end
    end

    initial
    begin : sink
        int idle;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            idle = sink_steady ? 0 : $urandom_range(0, 11);
            if (idle > 0 || stall_active)
            begin
                m_axis_tready <= 1'b0;
                repeat (idle) @(posedge clk);
                while (stall_active) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin : check_words
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.move             = m_axis_tdata[1:0];
            got.offset_hz        = m_axis_tdata[33:2];
            got.tuned_freq       = m_axis_tdata[65:34];
            got.recenter_request = m_axis_tdata[66];
            got.fast_active      = m_axis_tdata[67];
            got.step_used        = m_axis_tdata[84:68];
            if (expected_q.size() == 0)
            begin
                note_mismatch("unexpected word", '0, m_axis_tdata);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.move !== want.move)
                begin
                    note_mismatch("move", OUT_TDATA_W'(want.move), OUT_TDATA_W'(got.move));
                end
                if (got.offset_hz !== want.offset_hz)
                begin
                    note_mismatch("offset_hz", OUT_TDATA_W'(want.offset_hz),
                                  OUT_TDATA_W'(got.offset_hz));
                end
                if (got.tuned_freq !== want.tuned_freq)
                begin
                    note_mismatch("tuned_freq", OUT_TDATA_W'(want.tuned_freq),
                                  OUT_TDATA_W'(got.tuned_freq));
                end
                if (got.recenter_request !== want.recenter_request)
                begin
                    note_mismatch("recenter_request", OUT_TDATA_W'(want.recenter_request),
                                  OUT_TDATA_W'(got.recenter_request));
                end
                if (got.fast_active !== want.fast_active)
                begin
                    note_mismatch("fast_active", OUT_TDATA_W'(want.fast_active),
                                  OUT_TDATA_W'(got.fast_active));
                end
                if (got.step_used !== want.step_used)
                begin
                    note_mismatch("step_used", OUT_TDATA_W'(want.step_used),
                                  OUT_TDATA_W'(got.step_used));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_STEP;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_NORMAL_STEP;
        cfg_wdata     <= '0;
        tuner_cfg.normal_step   = RST_NORMAL_STEP;
        tuner_cfg.fast_step     = RST_FAST_STEP;
        tuner_cfg.short_gap_ms  = RST_SHORT_GAP_MS;
        tuner_cfg.cancel_gap_ms = RST_CANCEL_GAP_MS;
        tuner_cfg.trigger_count = RST_TRIGGER_COUNT;
        tuner_cfg.zoom_level    = RST_ZOOM_LEVEL;
        tuner_cfg.center_freq   = RST_CENTER_FREQ;
        tuner_cfg.cal_mode      = RST_CAL_MODE;
        last_step_ms = '0;
        fast_mode    = 1'b0;
        short_steps  = '0;
        tune_offset  = 0;
        knob_clock   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_defaults();
        test_register_extremes();
        test_random_settings();
        test_long_stall();
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_q.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### fine_tune_step_accelerator.f
rtl/ftsa_pkg.sv
rtl/ftsa_cfg_regs.sv
rtl/ftsa_step_core.sv
rtl/fine_tune_step_accelerator.sv
tb/testbench.sv
